FILE: design/bitt_pkg.sv
`default_nettype none

package bitt_pkg;

  localparam int NUM_PROBES     = 8;
  localparam int PERIOD_SECONDS = 1;

  localparam int CNT_W   = 24;
  localparam int OK_W    = 8;
  localparam int SEL_W   = 3;
  localparam int OP_W    = 3;
  localparam int LVL_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int PROBE_W  = (NUM_PROBES > OK_W) ? NUM_PROBES : OK_W;
  localparam int PERIOD_W = $clog2(PERIOD_SECONDS + 1);
  localparam int PROD_W   = CNT_W + PERIOD_W;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_RESET    = 3'd2,
    OP_PAUSE    = 3'd3,
    OP_CONTINUE = 3'd4,
    OP_TICK     = 3'd5
  } op_t;

  typedef enum logic [LVL_W-1:0] {
    LVL_LOW  = 2'd0,
    LVL_MID  = 2'd1,
    LVL_HIGH = 2'd2,
    LVL_KEEP = 2'd3
  } level_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUR_LOW  = 2'd0,
    CFG_DUR_MID  = 2'd1,
    CFG_DUR_HIGH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic advance;
    logic clear;
    logic count;
  } probe_ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: design/bitt_probe_bank.sv
`default_nettype none

module bitt_probe_bank (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bitt_pkg::probe_ctl_t      ctl,
  input  wire logic [bitt_pkg::OK_W-1:0]  probe_ok,
  input  wire logic [bitt_pkg::SEL_W-1:0] probe_select,
  output logic      [bitt_pkg::CNT_W-1:0] sel_count_nxt
);
  import bitt_pkg::*;

  logic [CNT_W-1:0]   cnt_r   [NUM_PROBES];
  logic [CNT_W-1:0]   cnt_nxt [NUM_PROBES];
  logic [PROBE_W-1:0] ok_ext;

  assign ok_ext = PROBE_W'(probe_ok);

  always_comb begin
    for (int k = 0; k < NUM_PROBES; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if (ctl.advance && ctl.clear) begin
        cnt_nxt[k] = '0;
      end else if (ctl.advance && ctl.count && (k < OK_W) && ok_ext[k]) begin
        cnt_nxt[k] = sat_inc(cnt_r[k]);
      end
    end
  end

  always_comb begin
    sel_count_nxt = '0;
    for (int k = 0; k < NUM_PROBES; k++) begin
      if (int'(probe_select) == k) begin
        sel_count_nxt = cnt_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_PROBES; k++) begin
      if (!rst_n) begin
        cnt_r[k] <= '0;
      end else begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/burn_in_test_timer_unit.sv
// Command-driven test timer. Each item carries one command (start, stop,
// reset, pause, continue or period tick) and yields exactly one result that
// shows the flags, the elapsed period count and the run count of the probe
// chosen by probe_select after that command. An item passes an input
// register and then a result register before its result is valid, and a
// new item is taken every cycle while the result side keeps up. The user
// must write the three duration registers through the cfg port only while
// no item is in flight; the block itself does not enforce this.
`default_nettype none

module burn_in_test_timer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [bitt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bitt_pkg::CNT_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bitt_pkg::OP_W-1:0]      in_operation,
  input  wire logic [bitt_pkg::LVL_W-1:0]     in_current_level,
  input  wire logic [bitt_pkg::OK_W-1:0]      in_probe_ok,
  input  wire logic [bitt_pkg::SEL_W-1:0]     in_probe_select,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_is_running,
  output logic                               out_is_paused,
  output logic                               out_is_done,
  output logic      [bitt_pkg::CNT_W-1:0]     out_elapsed_periods,
  output logic      [bitt_pkg::CNT_W-1:0]     out_probe_time
);
  import bitt_pkg::*;

  logic [CNT_W-1:0] dur_low_r, dur_mid_r, dur_high_r;

  logic             s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0]  s1_op_r;
  logic [LVL_W-1:0] s1_level_r;
  logic [OK_W-1:0]  s1_ok_r;
  logic [SEL_W-1:0] s1_sel_r;

  logic             running_r, running_nxt;
  logic             paused_r, paused_nxt;
  logic [CNT_W-1:0] duration_r, duration_nxt;
  logic [CNT_W-1:0] elapsed_r, elapsed_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] sel_count_nxt;
  logic [CNT_W-1:0] elapsed_inc;
  logic [PROD_W-1:0] elapsed_prod;

  logic       s1_take, s1_go, s2_free;
  probe_ctl_t probe_ctl;

  assign s2_free  = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign s1_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = s1_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_go ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  assign elapsed_inc  = sat_inc(elapsed_r);
  assign elapsed_prod = PROD_W'(elapsed_inc) * PROD_W'(PERIOD_SECONDS);

  always_comb begin
    running_nxt     = running_r;
    paused_nxt      = paused_r;
    duration_nxt    = duration_r;
    elapsed_nxt     = elapsed_r;
    probe_ctl.advance = s1_go;
    probe_ctl.clear   = 1'b0;
    probe_ctl.count   = 1'b0;
    case (op_t'(s1_op_r))
      OP_START: begin
        if (!running_r && !paused_r) begin
          case (level_t'(s1_level_r))
            LVL_LOW:  duration_nxt = dur_low_r;
            LVL_MID:  duration_nxt = dur_mid_r;
            LVL_HIGH: duration_nxt = dur_high_r;
            default:  duration_nxt = duration_r;
          endcase
          elapsed_nxt     = '0;
          running_nxt     = 1'b1;
          paused_nxt      = 1'b0;
          probe_ctl.clear = 1'b1;
        end
      end
      OP_STOP, OP_RESET: begin
        running_nxt     = 1'b0;
        paused_nxt      = 1'b0;
        elapsed_nxt     = '0;
        duration_nxt    = '0;
        probe_ctl.clear = (op_t'(s1_op_r) == OP_RESET);
      end
      OP_PAUSE: begin
        if (running_r && !paused_r) begin
          paused_nxt = 1'b1;
        end
      end
      OP_CONTINUE: begin
        if (running_r && paused_r) begin
          paused_nxt = 1'b0;
        end
      end
      OP_TICK: begin
        if (running_r && !paused_r) begin
          probe_ctl.count = 1'b1;
          elapsed_nxt     = elapsed_inc;
          if (elapsed_prod >= PROD_W'(duration_r)) begin
            running_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  bitt_probe_bank u_probe_bank (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (probe_ctl),
    .probe_ok      (s1_ok_r),
    .probe_select  (s1_sel_r),
    .sel_count_nxt (sel_count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_low_r  <= '0;
      dur_mid_r  <= '0;
      dur_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DUR_LOW:  dur_low_r  <= cfg_wdata;
        CFG_DUR_MID:  dur_mid_r  <= cfg_wdata;
        CFG_DUR_HIGH: dur_high_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      running_r   <= 1'b0;
      paused_r    <= 1'b0;
      duration_r  <= '0;
      elapsed_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        running_r  <= running_nxt;
        paused_r   <= paused_nxt;
        duration_r <= duration_nxt;
        elapsed_r  <= elapsed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_op_r    <= in_operation;
      s1_level_r <= in_current_level;
      s1_ok_r    <= in_probe_ok;
      s1_sel_r   <= in_probe_select;
    end
    if (s1_go) begin
      out_is_running      <= running_nxt;
      out_is_paused       <= running_nxt && paused_nxt;
      out_is_done         <= !running_nxt;
      out_elapsed_periods <= elapsed_nxt;
      out_probe_time      <= sel_count_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_paused_needs_running: assert property (@(posedge clk) disable iff (!rst_n)
    paused_r |-> running_r)
    else $error("paused flag set while timer not running");

  a_start_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(running_r) |-> (elapsed_r == '0))
    else $error("timer started with nonzero elapsed count");

  a_done_matches_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_is_done == !out_is_running))
    else $error("done and running flags disagree");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked item");

  a_state_holds_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_go |=> $stable(elapsed_r) && $stable(running_r))
    else $error("timer state changed without an item");

endmodule

`default_nettype wire
